// ===== hw/rtl/drpp_pkg.sv =====
// Shared constants, codes and types of the depth ROI point projector.
package drpp_pkg;

    // Table and coordinate sizing
    localparam int MAX_BOXES  = 16;
    localparam int COORD_BITS = 12;
    localparam int IDX_W      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);

    // Field widths
    localparam int DEPTH_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int CLASS_W  = 8;
    localparam int CENTER_W = 16;
    localparam int INV_W    = 24;
    localparam int XY_W     = 20;

    // Projection arithmetic widths
    localparam int PIX16_W    = COORD_BITS + 4;
    localparam int DIFF_W     = ((PIX16_W > CENTER_W) ? PIX16_W : CENTER_W) + 1;
    localparam int MAG_W      = DIFF_W - 1;
    localparam int PA_W       = MAG_W + DEPTH_W;
    localparam int PB_W       = PA_W + INV_W;
    localparam int FRAC_SHIFT = 28;
    localparam int Q_W        = PB_W + 1 - FRAC_SHIFT;

    // Input modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_PIXEL = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ORDER = 3'd4;

    // Configuration reset values
    localparam logic [CENTER_W-1:0] CENTER_X_RST  = 16'd5120;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST  = 16'd3840;
    localparam logic [INV_W-1:0]    INV_FOCAL_RST = 24'd31957;

    // Colour byte orders
    localparam logic [1:0] COLOR_RGB  = 2'd0;
    localparam logic [1:0] COLOR_BGR  = 2'd1;
    localparam logic [1:0] COLOR_MONO = 2'd2;

    // Part codes and class ids
    localparam logic [1:0] PART_NONE       = 2'd0;
    localparam logic [1:0] PART_POINT_HAND = 2'd1;
    localparam logic [1:0] PART_OTHER_HAND = 2'd2;
    localparam logic [1:0] PART_FACE       = 2'd3;
    localparam logic [CLASS_W-1:0] CLASS_HAND = 8'd0;
    localparam logic [CLASS_W-1:0] CLASS_FACE = 8'd1;

    typedef struct packed {
        logic [1:0]            mode;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_W-1:0]    depth_mm;
        logic [BYTE_W-1:0]     byte0;
        logic [BYTE_W-1:0]     byte1;
        logic [BYTE_W-1:0]     byte2;
        logic [COORD_BITS-1:0] box_left;
        logic [COORD_BITS-1:0] box_top;
        logic [COORD_BITS-1:0] box_width;
        logic [COORD_BITS-1:0] box_height;
        logic [CLASS_W-1:0]    box_class;
    } in_word_t;

    typedef struct packed {
        logic                     point_valid;
        logic signed [XY_W-1:0]   x_mm;
        logic signed [XY_W-1:0]   y_mm;
        logic [DEPTH_W-1:0]       z_mm;
        logic [CLASS_W-1:0]       label_class;
        logic [BYTE_W-1:0]        red;
        logic [BYTE_W-1:0]        green;
        logic [BYTE_W-1:0]        blue;
        logic [1:0]               part;
        logic                     frame_has_points;
    } out_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] wid;
        logic [COORD_BITS-1:0] hei;
        logic [CLASS_W-1:0]    cls;
    } box_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic check;
        logic scan_next;
        logic mul_a;
        logic mul_b;
        logic round;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;
        logic match;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

    // Round-to-nearest result magnitude, signed and saturated to XY_W bits
    function automatic logic [XY_W-1:0] sat_axis(logic [Q_W-1:0] q, logic neg);
        logic [Q_W-1:0]  neg_q;
        logic [XY_W-1:0] res;
        neg_q = ~q + Q_W'(1);
        if (neg)
        begin
            if (q > Q_W'(2 ** (XY_W - 1)))
                res = {1'b1, {(XY_W - 1){1'b0}}};
            else
                res = neg_q[XY_W-1:0];
        end
        else
        begin
            if (q > Q_W'(2 ** (XY_W - 1) - 1))
                res = {1'b0, {(XY_W - 1){1'b1}}};
            else
                res = q[XY_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/drpp_in_if.sv =====
// Input channel: valid/ready with one input word.
interface drpp_in_if;
    logic                 valid;
    logic                 ready;
    drpp_pkg::in_word_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/drpp_out_if.sv =====
// Output channel: valid/ready with one result word.
interface drpp_out_if;
    logic                 valid;
    logic                 ready;
    drpp_pkg::out_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/drpp_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
interface drpp_cfg_if;
    logic                 valid;
    logic                 ready;
    drpp_pkg::cfg_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/drpp_ctrl.sv =====
// Sequencing state machine: accept, box scan, multiply stages, result hand-off.
module drpp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_mode,
    output logic                in_ready,
    input  drpp_pkg::ctrl_sts_t sts,
    output drpp_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SCAN_RD  = 7'b0000010,
        ST_SCAN_CHK = 7'b0000100,
        ST_MUL_A    = 7'b0001000,
        ST_MUL_B    = 7'b0010000,
        ST_ROUND    = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Drive datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.check     = (state_reg == ST_SCAN_CHK);
        cmd.scan_next = (state_reg == ST_SCAN_CHK) && !sts.match && !sts.scan_last;
        cmd.mul_a     = (state_reg == ST_MUL_A);
        cmd.mul_b     = (state_reg == ST_MUL_B);
        cmd.round     = (state_reg == ST_ROUND);
        cmd.commit    = (state_reg == ST_FINISH) && sts.out_free;
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_mode == drpp_pkg::MODE_PIXEL))
                    state_next = sts.count_zero ? ST_MUL_A : ST_SCAN_RD;
            end
            ST_SCAN_RD:
                state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (sts.match || sts.scan_last)
                    state_next = ST_MUL_A;
                else
                    state_next = ST_SCAN_RD;
            end
            ST_MUL_A:
                state_next = ST_MUL_B;
            ST_MUL_B:
                state_next = ST_ROUND;
            ST_ROUND:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/drpp_dp.sv =====
// Datapath: config registers, box table, box match, projection and result register.
module drpp_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  drpp_pkg::in_word_t  in_data,
    input  logic                cfg_valid,
    input  drpp_pkg::cfg_word_t cfg_data,
    input  drpp_pkg::ctrl_cmd_t cmd,
    output drpp_pkg::ctrl_sts_t sts,
    output logic                out_valid,
    input  logic                out_ready,
    output drpp_pkg::out_word_t out_data
);

    // Configuration
    logic [drpp_pkg::CENTER_W-1:0] center_x_reg;
    logic [drpp_pkg::CENTER_W-1:0] center_y_reg;
    logic [drpp_pkg::INV_W-1:0]    inv_x_reg;
    logic [drpp_pkg::INV_W-1:0]    inv_y_reg;
    logic [1:0]                    color_order_reg;

    // Frame state
    logic [drpp_pkg::CNT_W-1:0] box_count_reg;
    logic                       point_set_reg;
    logic [drpp_pkg::IDX_W-1:0] point_box_reg;
    logic                       hit_seen_reg;

    // Box table
    drpp_pkg::box_t             box_mem [drpp_pkg::MAX_BOXES];
    drpp_pkg::box_t             rd_box_reg;
    logic                       load_we;
    drpp_pkg::box_t             new_box;
    logic [drpp_pkg::IDX_W-1:0] scan_idx_reg;

    // Pixel being worked on
    logic [drpp_pkg::COORD_BITS-1:0] u_reg;
    logic [drpp_pkg::COORD_BITS-1:0] v_reg;
    logic [drpp_pkg::DEPTH_W-1:0]    depth_reg;
    logic [drpp_pkg::BYTE_W-1:0]     b0_reg;
    logic [drpp_pkg::BYTE_W-1:0]     b1_reg;
    logic [drpp_pkg::BYTE_W-1:0]     b2_reg;
    logic                            hit_reg;
    logic [drpp_pkg::CLASS_W-1:0]    cls_reg;
    logic [drpp_pkg::IDX_W-1:0]      idx_reg;

    // Projection pipeline
    logic [drpp_pkg::DIFF_W-1:0] dx;
    logic [drpp_pkg::DIFF_W-1:0] dy;
    logic [drpp_pkg::DIFF_W-1:0] dx_neg;
    logic [drpp_pkg::DIFF_W-1:0] dy_neg;
    logic [drpp_pkg::MAG_W-1:0]  mag_x_reg;
    logic [drpp_pkg::MAG_W-1:0]  mag_y_reg;
    logic                        neg_x_reg;
    logic                        neg_y_reg;
    logic [drpp_pkg::PA_W-1:0]   pa_x_reg;
    logic [drpp_pkg::PA_W-1:0]   pa_y_reg;
    logic [drpp_pkg::PB_W-1:0]   pb_x_reg;
    logic [drpp_pkg::PB_W-1:0]   pb_y_reg;
    logic [drpp_pkg::PB_W:0]     sum_x;
    logic [drpp_pkg::PB_W:0]     sum_y;
    logic [drpp_pkg::Q_W-1:0]    q_x_reg;
    logic [drpp_pkg::Q_W-1:0]    q_y_reg;

    // Result
    logic                      out_valid_reg;
    drpp_pkg::out_word_t       out_reg;
    drpp_pkg::out_word_t       res;
    logic                      point;
    logic                      is_start;
    logic                      is_pixel;
    logic [drpp_pkg::COORD_BITS:0] right_edge;
    logic [drpp_pkg::COORD_BITS:0] bottom_edge;

    assign is_start = cmd.accept && (in_data.mode == drpp_pkg::MODE_START);
    assign is_pixel = cmd.accept && (in_data.mode == drpp_pkg::MODE_PIXEL);
    assign load_we  = cmd.accept && (in_data.mode == drpp_pkg::MODE_LOAD) &&
                      (box_count_reg < drpp_pkg::CNT_W'(drpp_pkg::MAX_BOXES));

    // Report status to the controller
    assign right_edge  = {1'b0, rd_box_reg.left} + {1'b0, rd_box_reg.wid};
    assign bottom_edge = {1'b0, rd_box_reg.top} + {1'b0, rd_box_reg.hei};
    always_comb
    begin
        sts            = '0;
        sts.count_zero = (box_count_reg == '0);
        sts.match      = (u_reg >= rd_box_reg.left) && ({1'b0, u_reg} <= right_edge) &&
                         (v_reg >= rd_box_reg.top) && ({1'b0, v_reg} <= bottom_edge);
        sts.scan_last  = ((drpp_pkg::CNT_W'(scan_idx_reg) + drpp_pkg::CNT_W'(1)) ==
                          box_count_reg);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= drpp_pkg::CENTER_X_RST;
            center_y_reg    <= drpp_pkg::CENTER_Y_RST;
            inv_x_reg       <= drpp_pkg::INV_FOCAL_RST;
            inv_y_reg       <= drpp_pkg::INV_FOCAL_RST;
            color_order_reg <= drpp_pkg::COLOR_RGB;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_data.index)
                drpp_pkg::CFG_CENTER_X:
                    center_x_reg <= cfg_data.value[drpp_pkg::CENTER_W-1:0];
                drpp_pkg::CFG_CENTER_Y:
                    center_y_reg <= cfg_data.value[drpp_pkg::CENTER_W-1:0];
                drpp_pkg::CFG_INV_FOCAL_X:
                    inv_x_reg <= cfg_data.value[drpp_pkg::INV_W-1:0];
                drpp_pkg::CFG_INV_FOCAL_Y:
                    inv_y_reg <= cfg_data.value[drpp_pkg::INV_W-1:0];
                drpp_pkg::CFG_COLOR_ORDER:
                    color_order_reg <= cfg_data.value[1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Box table: append on load, registered read at the scan index
    always_comb
    begin
        new_box.left = in_data.box_left;
        new_box.top  = in_data.box_top;
        new_box.wid  = in_data.box_width;
        new_box.hei  = in_data.box_height;
        new_box.cls  = in_data.box_class;
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
            box_mem[box_count_reg[drpp_pkg::IDX_W-1:0]] <= new_box;
        rd_box_reg <= box_mem[scan_idx_reg];
    end

    // Frame state: clear on start, count loads, track pointing hand on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_count_reg <= '0;
            point_set_reg <= 1'b0;
            point_box_reg <= '0;
            hit_seen_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (is_start)
            begin
                box_count_reg <= '0;
                point_set_reg <= 1'b0;
                point_box_reg <= '0;
                hit_seen_reg  <= 1'b0;
            end
            else if (load_we)
                box_count_reg <= box_count_reg + drpp_pkg::CNT_W'(1);

            if (is_pixel)
            begin
                hit_reg      <= 1'b0;
                scan_idx_reg <= '0;
            end
            else if (cmd.check && sts.match)
                hit_reg <= 1'b1;
            else if (cmd.scan_next)
                scan_idx_reg <= scan_idx_reg + drpp_pkg::IDX_W'(1);

            if (cmd.commit)
            begin
                if (hit_reg)
                    hit_seen_reg <= 1'b1;
                if (point && (cls_reg == drpp_pkg::CLASS_HAND) && !point_set_reg)
                begin
                    point_set_reg <= 1'b1;
                    point_box_reg <= idx_reg;
                end
            end

            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Offsets from the principal point in 1/16 pixel units
    always_comb
    begin
        dx     = drpp_pkg::DIFF_W'({in_data.col, 4'b0000}) - drpp_pkg::DIFF_W'(center_x_reg);
        dy     = drpp_pkg::DIFF_W'({in_data.row, 4'b0000}) - drpp_pkg::DIFF_W'(center_y_reg);
        dx_neg = ~dx + drpp_pkg::DIFF_W'(1);
        dy_neg = ~dy + drpp_pkg::DIFF_W'(1);
        sum_x  = {1'b0, pb_x_reg} +
                 ((drpp_pkg::PB_W + 1)'(1) << (drpp_pkg::FRAC_SHIFT - 1));
        sum_y  = {1'b0, pb_y_reg} +
                 ((drpp_pkg::PB_W + 1)'(1) << (drpp_pkg::FRAC_SHIFT - 1));
    end

    // Capture the pixel, latch the match, run the multiply and round stages
    always_ff @(posedge clk)
    begin
        if (is_pixel)
        begin
            u_reg     <= in_data.col;
            v_reg     <= in_data.row;
            depth_reg <= in_data.depth_mm;
            b0_reg    <= in_data.byte0;
            b1_reg    <= in_data.byte1;
            b2_reg    <= in_data.byte2;
            neg_x_reg <= dx[drpp_pkg::DIFF_W-1];
            neg_y_reg <= dy[drpp_pkg::DIFF_W-1];
            mag_x_reg <= dx[drpp_pkg::DIFF_W-1] ? dx_neg[drpp_pkg::MAG_W-1:0]
                                                : dx[drpp_pkg::MAG_W-1:0];
            mag_y_reg <= dy[drpp_pkg::DIFF_W-1] ? dy_neg[drpp_pkg::MAG_W-1:0]
                                                : dy[drpp_pkg::MAG_W-1:0];
        end
        if (cmd.check && sts.match)
        begin
            cls_reg <= rd_box_reg.cls;
            idx_reg <= scan_idx_reg;
        end
        if (cmd.mul_a)
        begin
            pa_x_reg <= drpp_pkg::PA_W'(mag_x_reg) * drpp_pkg::PA_W'(depth_reg);
            pa_y_reg <= drpp_pkg::PA_W'(mag_y_reg) * drpp_pkg::PA_W'(depth_reg);
        end
        if (cmd.mul_b)
        begin
            pb_x_reg <= drpp_pkg::PB_W'(pa_x_reg) * drpp_pkg::PB_W'(inv_x_reg);
            pb_y_reg <= drpp_pkg::PB_W'(pa_y_reg) * drpp_pkg::PB_W'(inv_y_reg);
        end
        if (cmd.round)
        begin
            q_x_reg <= sum_x[drpp_pkg::PB_W:drpp_pkg::FRAC_SHIFT];
            q_y_reg <= sum_y[drpp_pkg::PB_W:drpp_pkg::FRAC_SHIFT];
        end
        if (cmd.commit)
            out_reg <= res;
    end

    // Assemble the result word
    assign point = hit_reg && (depth_reg != '0);
    always_comb
    begin
        res                  = '0;
        res.frame_has_points = hit_seen_reg || hit_reg;
        if (hit_reg)
            res.label_class = cls_reg;
        if (point)
        begin
            res.point_valid = 1'b1;
            res.x_mm        = drpp_pkg::sat_axis(q_x_reg, neg_x_reg);
            res.y_mm        = drpp_pkg::sat_axis(q_y_reg, neg_y_reg);
            res.z_mm        = depth_reg;
            priority if (color_order_reg == drpp_pkg::COLOR_BGR)
            begin
                res.red   = b2_reg;
                res.green = b1_reg;
                res.blue  = b0_reg;
            end
            else if (color_order_reg == drpp_pkg::COLOR_MONO)
            begin
                res.red   = b0_reg;
                res.green = b0_reg;
                res.blue  = b0_reg;
            end
            else
            begin
                res.red   = b0_reg;
                res.green = b1_reg;
                res.blue  = b2_reg;
            end
            priority if (cls_reg == drpp_pkg::CLASS_HAND)
                res.part = (!point_set_reg || (point_box_reg == idx_reg)) ?
                           drpp_pkg::PART_POINT_HAND : drpp_pkg::PART_OTHER_HAND;
            else if (cls_reg == drpp_pkg::CLASS_FACE)
                res.part = drpp_pkg::PART_FACE;
            else
                res.part = drpp_pkg::PART_NONE;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Table never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        box_count_reg <= drpp_pkg::CNT_W'(drpp_pkg::MAX_BOXES))
        else $error("box count beyond table depth");

    // A result is loaded only into a free output register
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a pending word");

    // Pointing hand selection drops only at a frame start
    a_point_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(point_set_reg) |-> $past(is_start))
        else $error("pointing hand cleared without frame start");

    // Frame hit flag drops only at a frame start
    a_seen_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(hit_seen_reg) |-> $past(is_start))
        else $error("frame hit flag cleared without frame start");

endmodule

// ===== hw/rtl/depth_roi_point_projector.sv =====
// Depth ROI point projector: one input word per cycle in idle; a pixel word is scanned
// against the box table one box at a time, each through a read state and a check state,
// then projected through two multiply stages and a rounding stage, and a finish state that
// waits for a free output register. The input is held off for the whole of a pixel, over
// the boxes examined (up to the loaded count, stopping at the first match); start and load
// words leave the block idle. The result sits in an output register; the next word is taken
// as soon as the result is loaded there. Configuration writes are taken every cycle.
module depth_roi_point_projector
(
    input  logic        clk,
    input  logic        rst_n,
    drpp_in_if.sink     in_ch,
    drpp_out_if.source  out_ch,
    drpp_cfg_if.sink    cfg_ch
);

    drpp_pkg::ctrl_cmd_t cmd;
    drpp_pkg::ctrl_sts_t sts;

    // Accept configuration writes at any time
    assign cfg_ch.ready = 1'b1;

    drpp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_mode  (in_ch.data.mode),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    drpp_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_ch.data),
        .cfg_valid (cfg_ch.valid),
        .cfg_data  (cfg_ch.data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data)
    );

endmodule

// ===== verif/depth_roi_point_projector_test.sv =====
// Self-checking testbench for the depth ROI point projector: directed and random frames.
`timescale 1ns / 1ps

module depth_roi_point_projector_test;

    // Mode code the block ignores, and the spare colour order that falls back to RGB
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam logic [1:0] COLOR_SPARE = 2'd3;

    localparam int SETTLE_CYCLES = 60;    // covers the longest pixel, with a full box scan
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_WORDS   = 200;

    logic clk;
    logic rst_n;

    drpp_in_if  in_ch ();
    drpp_out_if out_ch ();
    drpp_cfg_if cfg_ch ();

    depth_roi_point_projector dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Projection state mirrored from the block
    drpp_pkg::box_t                  box_store [drpp_pkg::MAX_BOXES];
    int                              box_fill;
    bit                              hand_set;
    int                              hand_idx;
    bit                              frame_hit;
    logic [drpp_pkg::CENTER_W-1:0]   ctr_x;
    logic [drpp_pkg::CENTER_W-1:0]   ctr_y;
    logic [drpp_pkg::INV_W-1:0]      inv_fx;
    logic [drpp_pkg::INV_W-1:0]      inv_fy;
    logic [1:0]                      color_sel;

    drpp_pkg::out_word_t expected_points [$];
    int        mismatch_count;
    int        stim_words;
    int        idle_cycles;
    bit        src_steady;
    bit        snk_steady;
    bit        hold_request;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Back-project one axis: round to nearest, ties away from zero, then saturate
    function automatic logic [drpp_pkg::XY_W-1:0] scale_axis(
        input logic [drpp_pkg::COORD_BITS-1:0] pix,
        input logic [drpp_pkg::CENTER_W-1:0]   ctr,
        input logic [drpp_pkg::DEPTH_W-1:0]    dep,
        input logic [drpp_pkg::INV_W-1:0]      inv);
        longint          diff;
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned q;
        logic [63:0]     neg_q;
        diff = longint'(pix) * 16 - longint'(ctr);
        mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
        prod = mag * longint'(dep) * longint'(inv);
        q    = (prod + (64'd1 << 27)) >> 28;
        if (diff < 0)
        begin
            if (q > 64'd524288)
                return {1'b1, {(drpp_pkg::XY_W - 1){1'b0}}};
            neg_q = -q;
            return neg_q[drpp_pkg::XY_W-1:0];
        end
        if (q > 64'd524287)
            return {1'b0, {(drpp_pkg::XY_W - 1){1'b1}}};
        return q[drpp_pkg::XY_W-1:0];
    endfunction

    // Advance the mirrored state by one word; return 1 when the word is a pixel, which yields a result word
    function automatic bit predict_projection(input drpp_pkg::in_word_t w,
                                              output drpp_pkg::out_word_t res);
        int                           i;
        bit                           hit;
        int                           idx;
        logic [drpp_pkg::CLASS_W-1:0] cls;
        res = '0;
        hit = 1'b0;
        idx = 0;
        cls = '0;
        case (w.mode)
            drpp_pkg::MODE_START:
            begin
                box_fill  = 0;
                hand_set  = 1'b0;
                hand_idx  = 0;
                frame_hit = 1'b0;
                return 1'b0;
            end
            drpp_pkg::MODE_LOAD:
            begin
                if (box_fill < drpp_pkg::MAX_BOXES)
                begin
                    box_store[box_fill] = '{left: w.box_left, top: w.box_top,
                                            wid: w.box_width, hei: w.box_height,
                                            cls: w.box_class};
                    box_fill++;
                end
                return 1'b0;
            end
            drpp_pkg::MODE_PIXEL:
                ;
            default:
                return 1'b0;
        endcase

        // First box in load order wins; ends are inclusive and do not wrap
        for (i = 0; i < box_fill; i++)
        begin
            if (int'(w.col) >= int'(box_store[i].left) &&
                int'(w.col) <= int'(box_store[i].left) + int'(box_store[i].wid) &&
                int'(w.row) >= int'(box_store[i].top) &&
                int'(w.row) <= int'(box_store[i].top) + int'(box_store[i].hei))
            begin
                hit = 1'b1;
                idx = i;
                cls = box_store[i].cls;
                break;
            end
        end

        if (hit)
        begin
            frame_hit       = 1'b1;
            res.label_class = cls;
            if (w.depth_mm != '0)
            begin
                res.point_valid = 1'b1;
                res.x_mm        = scale_axis(w.col, ctr_x, w.depth_mm, inv_fx);
                res.y_mm        = scale_axis(w.row, ctr_y, w.depth_mm, inv_fy);
                res.z_mm        = w.depth_mm;
                case (color_sel)
                    drpp_pkg::COLOR_BGR:
                    begin
                        res.red   = w.byte2;
                        res.green = w.byte1;
                        res.blue  = w.byte0;
                    end
                    drpp_pkg::COLOR_MONO:
                    begin
                        res.red   = w.byte0;
                        res.green = w.byte0;
                        res.blue  = w.byte0;
                    end
                    default:
                    begin
                        res.red   = w.byte0;
                        res.green = w.byte1;
                        res.blue  = w.byte2;
                    end
                endcase
                // The first class-0 box that yields a point is the pointing hand
                if (cls == drpp_pkg::CLASS_HAND)
                begin
                    if (!hand_set)
                    begin
                        hand_set = 1'b1;
                        hand_idx = idx;
                    end
                    res.part = (hand_idx == idx) ? drpp_pkg::PART_POINT_HAND
                                                 : drpp_pkg::PART_OTHER_HAND;
                end
                else if (cls == drpp_pkg::CLASS_FACE)
                    res.part = drpp_pkg::PART_FACE;
                else
                    res.part = drpp_pkg::PART_NONE;
            end
        end
        res.frame_has_points = frame_hit;
        return 1'b1;
    endfunction

    // Word with every field random
    function automatic drpp_pkg::in_word_t random_word();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(drpp_pkg::in_word_t)-1:0];
    endfunction

    function automatic drpp_pkg::in_word_t start_word();
        drpp_pkg::in_word_t w;
        w      = random_word();
        w.mode = drpp_pkg::MODE_START;
        return w;
    endfunction

    function automatic drpp_pkg::in_word_t load_word(input drpp_pkg::box_t b);
        drpp_pkg::in_word_t w;
        w            = random_word();
        w.mode       = drpp_pkg::MODE_LOAD;
        w.box_left   = b.left;
        w.box_top    = b.top;
        w.box_width  = b.wid;
        w.box_height = b.hei;
        w.box_class  = b.cls;
        return w;
    endfunction

    function automatic drpp_pkg::in_word_t pixel_word(input int u, input int v,
                                                      input int dep);
        drpp_pkg::in_word_t w;
        w          = random_word();
        w.mode     = drpp_pkg::MODE_PIXEL;
        w.col      = u[drpp_pkg::COORD_BITS-1:0];
        w.row      = v[drpp_pkg::COORD_BITS-1:0];
        w.depth_mm = dep[drpp_pkg::DEPTH_W-1:0];
        return w;
    endfunction

    function automatic int random_depth();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        if (r < 25)
            return 65535;
        if (r < 45)
            return $urandom_range(1, 255);
        return $urandom_range(0, 65535);
    endfunction

    // Box: mostly small, sometimes stacked on the previous one to exercise priority
    function automatic drpp_pkg::box_t random_box(input bit have_prev,
                                                  input drpp_pkg::box_t prev);
        drpp_pkg::box_t b;
        int             r;
        r = $urandom_range(0, 99);
        if (have_prev && r < 30)
        begin
            b.left = prev.left + drpp_pkg::COORD_BITS'($urandom_range(0, 20));
            b.top  = prev.top + drpp_pkg::COORD_BITS'($urandom_range(0, 20));
        end
        else
        begin
            b.left = drpp_pkg::COORD_BITS'($urandom_range(0, 4095));
            b.top  = drpp_pkg::COORD_BITS'($urandom_range(0, 4095));
        end
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            b.wid = drpp_pkg::COORD_BITS'($urandom_range(0, 40));
            b.hei = drpp_pkg::COORD_BITS'($urandom_range(0, 40));
        end
        else
        begin
            b.wid = drpp_pkg::COORD_BITS'($urandom_range(0, 4095));
            b.hei = drpp_pkg::COORD_BITS'($urandom_range(0, 4095));
        end
        r = $urandom_range(0, 99);
        if (r < 50)
            b.cls = drpp_pkg::CLASS_HAND;
        else if (r < 80)
            b.cls = drpp_pkg::CLASS_FACE;
        else
            b.cls = drpp_pkg::CLASS_W'($urandom_range(0, 255));
        return b;
    endfunction

    // Offer one word, hold it until taken, then record what it should produce
    task automatic send_word(input drpp_pkg::in_word_t w);
        drpp_pkg::out_word_t res;
        int                  gap;
        gap = pick_gap(src_steady);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (predict_projection(w, res))
            expected_points = {expected_points, res};
        if (w.mode != MODE_SPARE)
            stim_words++;
    endtask

    // Drop valid and wait for the block to go idle
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all five registers back to back; call only while idle
    task automatic apply_settings(input logic [drpp_pkg::CENTER_W-1:0] cx,
                                  input logic [drpp_pkg::CENTER_W-1:0] cy,
                                  input logic [drpp_pkg::INV_W-1:0] fx,
                                  input logic [drpp_pkg::INV_W-1:0] fy,
                                  input logic [1:0] order);
        logic [drpp_pkg::CFG_IDX_W-1:0]  idxs [5];
        logic [drpp_pkg::CFG_DATA_W-1:0] vals [5];
        int                              k;
        idxs = '{drpp_pkg::CFG_CENTER_X, drpp_pkg::CFG_CENTER_Y, drpp_pkg::CFG_INV_FOCAL_X,
                 drpp_pkg::CFG_INV_FOCAL_Y, drpp_pkg::CFG_COLOR_ORDER};
        vals = '{drpp_pkg::CFG_DATA_W'(cx), drpp_pkg::CFG_DATA_W'(cy), fx, fy,
                 drpp_pkg::CFG_DATA_W'(order)};
        for (k = 0; k < 5; k++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= {idxs[k], vals[k]};
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            case (idxs[k])
                drpp_pkg::CFG_CENTER_X:    ctr_x     = vals[k][drpp_pkg::CENTER_W-1:0];
                drpp_pkg::CFG_CENTER_Y:    ctr_y     = vals[k][drpp_pkg::CENTER_W-1:0];
                drpp_pkg::CFG_INV_FOCAL_X: inv_fx    = vals[k];
                drpp_pkg::CFG_INV_FOCAL_Y: inv_fy    = vals[k];
                drpp_pkg::CFG_COLOR_ORDER: color_sel = vals[k][1:0];
                default:                   ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // One frame: start, none to MAX_BOXES + 2 boxes, pixels mostly aimed at or near them, some noise
    task automatic run_frame(input int n_pixels);
        drpp_pkg::box_t     boxes [$];
        drpp_pkg::box_t     bx;
        drpp_pkg::in_word_t w;
        int                 n_boxes;
        int                 r;
        int                 k;
        int                 u;
        int                 v;
        r = $urandom_range(0, 99);
        if (r < 80)
            n_boxes = $urandom_range(1, 6);
        else if (r < 92)
            n_boxes = $urandom_range(drpp_pkg::MAX_BOXES - 2, drpp_pkg::MAX_BOXES + 2);
        else
            n_boxes = 0;
        send_word(start_word());
        for (k = 0; k < n_boxes; k++)
        begin
            bx = random_box(boxes.size() != 0, (boxes.size() != 0) ? boxes[$] : '0);
            boxes = {boxes, bx};
            send_word(load_word(bx));
        end
        for (k = 0; k < n_pixels; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                // Noise: any mode, any content
                w = random_word();
                send_word(w);
            end
            else if (boxes.size() != 0 && r < 80)
            begin
                bx = boxes[$urandom_range(0, boxes.size() - 1)];
                u  = int'(bx.left) + $urandom_range(0, int'(bx.wid) + 1)
                     - (($urandom_range(0, 7) == 0) ? 1 : 0);
                v  = int'(bx.top) + $urandom_range(0, int'(bx.hei) + 1)
                     - (($urandom_range(0, 7) == 0) ? 1 : 0);
                send_word(pixel_word(u, v, random_depth()));
            end
            else
                send_word(pixel_word($urandom_range(0, 4095), $urandom_range(0, 4095),
                                     random_depth()));
        end
    endtask

    // Pixels and a load before any start frame, and an ignored mode
    task automatic test_reset_state();
        send_word(pixel_word(0, 0, 1000));
        send_word(load_word('{left: 12'd10, top: 12'd10, wid: 12'd5, hei: 12'd5,
                              cls: drpp_pkg::CLASS_HAND}));
        send_word(pixel_word(12, 12, 1000));
        send_word(pixel_word(4095, 4095, 65535));
        w_spare();
    endtask

    task automatic w_spare();
        drpp_pkg::in_word_t w;
        w      = random_word();
        w.mode = MODE_SPARE;
        send_word(w);
    endtask

    // Box edges, priority, pointing hand selection, zero depth, odd class
    task automatic test_box_labels();
        drpp_pkg::in_word_t w;
        send_word(start_word());
        send_word(load_word('{left: 12'd100, top: 12'd100, wid: 12'd10, hei: 12'd10,
                              cls: drpp_pkg::CLASS_HAND}));
        send_word(load_word('{left: 12'd200, top: 12'd200, wid: 12'd0, hei: 12'd0,
                              cls: drpp_pkg::CLASS_HAND}));
        send_word(load_word('{left: 12'd300, top: 12'd300, wid: 12'd20, hei: 12'd20,
                              cls: drpp_pkg::CLASS_FACE}));
        send_word(load_word('{left: 12'd4095, top: 12'd4095, wid: 12'd4095, hei: 12'd4095,
                              cls: 8'd255}));
        // Zero depth still labels and marks the frame, but does not pick the hand
        send_word(pixel_word(100, 100, 0));
        send_word(pixel_word(200, 200, 65535));
        send_word(pixel_word(110, 110, 1));
        send_word(pixel_word(111, 110, 500));
        send_word(pixel_word(300, 320, 2000));
        w = pixel_word(4095, 4095, 65535);
        w.byte0 = 8'hff;
        w.byte1 = 8'h00;
        w.byte2 = 8'hff;
        send_word(w);
        send_word(pixel_word(0, 0, 65535));
        send_word(load_word('{left: 12'd0, top: 12'd0, wid: 12'd4095, hei: 12'd4095,
                              cls: drpp_pkg::CLASS_HAND}));
        send_word(pixel_word(0, 0, 65535));
        send_word(pixel_word(105, 105, 700));
        send_word(start_word());
        send_word(pixel_word(0, 0, 65535));
    endtask

    // Hold off the output long enough for the block to back up into its input
    task automatic test_output_stall();
        int k;
        quiesce();
        send_word(start_word());
        send_word(load_word('{left: 12'd320, top: 12'd240, wid: 12'd63, hei: 12'd63,
                              cls: drpp_pkg::CLASS_HAND}));
        src_steady   = 1'b1;
        hold_request = 1'b1;
        for (k = 0; k < 24; k++)
            send_word(pixel_word($urandom_range(320, 383), $urandom_range(240, 303),
                                 random_depth()));
        src_steady = 1'b0;
    endtask

    // Random frames under a sweep of register settings, extremes included
    task automatic test_settings_sweep();
        int phase;
        int target;
        for (phase = 0; phase < 5; phase++)
        begin
            quiesce();
            case (phase)
                0: apply_settings(drpp_pkg::CENTER_X_RST, drpp_pkg::CENTER_Y_RST,
                                  drpp_pkg::INV_FOCAL_RST, drpp_pkg::INV_FOCAL_RST,
                                  drpp_pkg::COLOR_RGB);
                1: apply_settings('0, '0, '1, '1, drpp_pkg::COLOR_BGR);
                2: apply_settings('1, '1, '0, drpp_pkg::INV_W'(1), drpp_pkg::COLOR_MONO);
                3: apply_settings(drpp_pkg::CENTER_W'($urandom),
                                  drpp_pkg::CENTER_W'($urandom),
                                  drpp_pkg::INV_W'($urandom),
                                  drpp_pkg::INV_W'($urandom), COLOR_SPARE);
                default: apply_settings(drpp_pkg::CENTER_W'($urandom_range(0, 65535)),
                                        drpp_pkg::CENTER_W'($urandom_range(0, 65535)),
                                        drpp_pkg::INV_W'($urandom_range(1000, 2000000)),
                                        drpp_pkg::INV_W'($urandom_range(1000, 2000000)),
                                        2'($urandom_range(0, 3)));
            endcase
            src_steady = (phase == 2);
            snk_steady = (phase == 2 || phase == 4);
            target     = stim_words + PHASE_WORDS;
            while (stim_words < target)
                run_frame($urandom_range(8, 50));
        end
        src_steady = 1'b0;
        snk_steady = 1'b0;
    endtask

    // Output pacing, with a long hold when asked
    initial
    begin : sink_pacing
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = pick_gap(snk_steady);
                if (stall > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ch.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int want, input int got,
                               input logic got_known);
        if (!got_known || want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each delivered word with the oldest expected point
    always @(posedge clk)
    begin : result_check
        drpp_pkg::out_word_t want;
        drpp_pkg::out_word_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                check_field("point_valid", want.point_valid, got.point_valid,
                            !$isunknown(got.point_valid));
                check_field("x_mm", $signed(want.x_mm), $signed(got.x_mm),
                            !$isunknown(got.x_mm));
                check_field("y_mm", $signed(want.y_mm), $signed(got.y_mm),
                            !$isunknown(got.y_mm));
                check_field("z_mm", want.z_mm, got.z_mm, !$isunknown(got.z_mm));
                check_field("label_class", want.label_class, got.label_class,
                            !$isunknown(got.label_class));
                check_field("red", want.red, got.red, !$isunknown(got.red));
                check_field("green", want.green, got.green, !$isunknown(got.green));
                check_field("blue", want.blue, got.blue, !$isunknown(got.blue));
                check_field("part", want.part, got.part, !$isunknown(got.part));
                check_field("frame_has_points", want.frame_has_points, got.frame_has_points,
                            !$isunknown(got.frame_has_points));
            end
        end
    end

    // Watchdog: end the run if no channel moves a word for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        mismatch_count = 0;
        stim_words     = 0;
        idle_cycles    = 0;
        src_steady     = 1'b0;
        snk_steady     = 1'b0;
        hold_request   = 1'b0;
        box_fill       = 0;
        hand_set       = 1'b0;
        hand_idx       = 0;
        frame_hit      = 1'b0;
        ctr_x          = drpp_pkg::CENTER_X_RST;
        ctr_y          = drpp_pkg::CENTER_Y_RST;
        inv_fx         = drpp_pkg::INV_FOCAL_RST;
        inv_fy         = drpp_pkg::INV_FOCAL_RST;
        color_sel      = drpp_pkg::COLOR_RGB;
        for (int i = 0; i < drpp_pkg::MAX_BOXES; i++)
            box_store[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_box_labels();
        test_output_stall();
        test_settings_sweep();
        quiesce();

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
